@@ hw/rtl/ptm_pkg.sv @@
// Shared types, constants and command/status structs for the PAE page table mapper.
package ptm_pkg;

    // Default number of table memory pages
    localparam int PTM_TABLE_PAGES = 64;

    // Field widths
    localparam int VPN_W       = 20;
    localparam int PPN_W       = 28;
    localparam int ENTRY_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int ADDED_W     = 2;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;

    // Table geometry: 512 entries per table, 4-entry top table
    localparam int ENTRY_IDX_W = 9;
    localparam int TOP_IDX_W   = 2;
    localparam int PFN_LSB     = 12;

    // Entry flag words for links written by the walker
    localparam logic [ENTRY_W-1:0] LINK_TOP_FLAGS = 64'h1;
    localparam logic [ENTRY_W-1:0] LINK_DIR_FLAGS = 64'h7;

    // Register reset values
    localparam logic [CFG_W-1:0] ROOT_RST      = 6'd0;
    localparam logic [CFG_W-1:0] FREE_BASE_RST = 6'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_MAPPED  = 2'd0,
        ST_PRESENT = 2'd1,
        ST_NO_ROOM = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOT      = 2'd0,
        CFG_FREE_BASE = 2'd1,
        CFG_NX        = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RD_TOP,
        RD_DIR,
        RD_LEAF
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_CLEAR,
        WR_TOP_LINK,
        WR_DIR_LINK,
        WR_LEAF
    } t_wr_sel;

    typedef enum logic [1:0] {
        CLR_PAGE_ZERO,
        CLR_DIR_PAGE,
        CLR_LEAF_PAGE
    } t_clr_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_TOP,
        S_TOP,
        S_DIR,
        S_LEAF,
        S_CLR_DIR,
        S_LINK_TOP,
        S_CLR_LEAF,
        S_LINK_DIR,
        S_WR_LEAF,
        S_RESULT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        t_clr_sel clr_sel;
        logic     cap_dir;
        logic     cap_leaf;
        logic     take_dir;
        logic     take_leaf;
        logic     pend_en;
        t_status  pend_kind;
        logic     out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic present;
        logic clr_last;
        logic room_one;
        logic room_two;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/pae_page_table_mapper.sv @@
// Top level of the PAE three-level page table mapper.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  in        sink       i_in_valid / o_in_ready    virt_page, phys_page, 4 flag bits
//  out       source     o_out_valid / i_out_ready  status, tables_added, leaf_entry
//  cfg       sink       i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One item in flight. When the walk finds all three levels it makes three dependent
// reads on the single table memory read port, then loads the pending result and the
// result register; the next item can be taken in the cycle after the result is loaded.
// A new page table, or a new directory and page table, adds a clear pass per page:
// each fresh table page is cleared one entry per cycle through the memory write port.
// After reset, page 0 (the reset root page) is cleared; o_in_ready stays low meanwhile,
// configuration writes are taken.
// The finished result sits in the output register; the next item is accepted while
// it waits, and only the following result stalls on i_out_ready.
module pae_page_table_mapper #(
    parameter int TABLE_PAGES = ptm_pkg::PTM_TABLE_PAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptm_pkg::CFG_W-1:0]     i_cfg_data,
    // request item
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptm_pkg::VPN_W-1:0]     i_virt_page,
    input  logic [ptm_pkg::PPN_W-1:0]     i_phys_page,
    input  logic                          i_allow_write,
    input  logic                          i_allow_user,
    input  logic                          i_mark_shared,
    input  logic                          i_want_no_exec,
    // result item
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptm_pkg::STATUS_W-1:0]  o_status,
    output logic [ptm_pkg::ADDED_W-1:0]   o_tables_added,
    output logic [ptm_pkg::ENTRY_W-1:0]   o_leaf_entry
);
    import ptm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: reset clear pass, walk, allocate/clear/link, result hand-off
    ptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table memory, bump allocator, config registers and result register
    ptm_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_virt_page    (i_virt_page),
        .i_phys_page    (i_phys_page),
        .i_allow_write  (i_allow_write),
        .i_allow_user   (i_allow_user),
        .i_mark_shared  (i_mark_shared),
        .i_want_no_exec (i_want_no_exec),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_tables_added (o_tables_added),
        .o_leaf_entry   (o_leaf_entry)
    );

endmodule

@@ hw/rtl/ptm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/ptm_ctrl.sv @@
// Walk controller: sequences table reads, page clears, links and the result.
module ptm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ptm_pkg::t_sts i_sts,
    output ptm_pkg::t_cmd o_cmd
);
    import ptm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_RD_TOP;
            end
            S_RD_TOP: n_state = S_TOP;
            S_TOP: begin
                if (i_sts.present)       n_state = S_DIR;
                else if (i_sts.room_two) n_state = S_CLR_DIR;
                else                     n_state = S_RESULT;
            end
            S_DIR: begin
                if (i_sts.present)       n_state = S_LEAF;
                else if (i_sts.room_one) n_state = S_CLR_LEAF;
                else                     n_state = S_RESULT;
            end
            S_LEAF:     n_state = S_RESULT;
            S_CLR_DIR: begin
                if (i_sts.clr_last) n_state = S_LINK_TOP;
            end
            S_LINK_TOP: n_state = S_CLR_LEAF;
            S_CLR_LEAF: begin
                if (i_sts.clr_last) n_state = S_LINK_DIR;
            end
            S_LINK_DIR: n_state = S_WR_LEAF;
            S_WR_LEAF:  n_state = S_RESULT;
            S_RESULT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_CLEAR;
                o_cmd.clr_sel = CLR_PAGE_ZERO;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_RD_TOP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TOP;
            end
            S_TOP: begin
                if (i_sts.present) begin
                    o_cmd.cap_dir = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_DIR;
                end else if (i_sts.room_two) begin
                    o_cmd.take_dir = 1'b1;
                end else begin
                    o_cmd.pend_en   = 1'b1;
                    o_cmd.pend_kind = ST_NO_ROOM;
                end
            end
            S_DIR: begin
                if (i_sts.present) begin
                    o_cmd.cap_leaf = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = RD_LEAF;
                end else if (i_sts.room_one) begin
                    o_cmd.take_leaf = 1'b1;
                end else begin
                    o_cmd.pend_en   = 1'b1;
                    o_cmd.pend_kind = ST_NO_ROOM;
                end
            end
            S_LEAF: begin
                o_cmd.pend_en = 1'b1;
                if (i_sts.present) begin
                    o_cmd.pend_kind = ST_PRESENT;
                end else begin
                    o_cmd.pend_kind = ST_MAPPED;
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.wr_sel    = WR_LEAF;
                end
            end
            S_CLR_DIR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_CLEAR;
                o_cmd.clr_sel = CLR_DIR_PAGE;
            end
            S_LINK_TOP: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_sel    = WR_TOP_LINK;
                o_cmd.take_leaf = 1'b1;
            end
            S_CLR_LEAF: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WR_CLEAR;
                o_cmd.clr_sel = CLR_LEAF_PAGE;
            end
            S_LINK_DIR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_DIR_LINK;
            end
            S_WR_LEAF: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_sel    = WR_LEAF;
                o_cmd.pend_en   = 1'b1;
                o_cmd.pend_kind = ST_MAPPED;
            end
            S_RESULT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/ptm_datapath.sv @@
// Datapath: config registers, page allocator, table memory, address/data muxes, result regs.
module ptm_datapath #(
    parameter int TABLE_PAGES = ptm_pkg::PTM_TABLE_PAGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptm_pkg::t_cmd                  i_cmd,
    output ptm_pkg::t_sts                  o_sts,
    input  logic                           i_cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [ptm_pkg::VPN_W-1:0]      i_virt_page,
    input  logic [ptm_pkg::PPN_W-1:0]      i_phys_page,
    input  logic                           i_allow_write,
    input  logic                           i_allow_user,
    input  logic                           i_mark_shared,
    input  logic                           i_want_no_exec,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ptm_pkg::STATUS_W-1:0]   o_status,
    output logic [ptm_pkg::ADDED_W-1:0]    o_tables_added,
    output logic [ptm_pkg::ENTRY_W-1:0]    o_leaf_entry
);
    import ptm_pkg::*;

    localparam int PW         = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int AW         = PW + ENTRY_IDX_W;
    localparam int DEPTH      = TABLE_PAGES * (2 ** ENTRY_IDX_W);
    localparam int NFP_MAX    = (TABLE_PAGES > 63) ? TABLE_PAGES : 63;
    localparam int NW         = $clog2(NFP_MAX + 1);
    localparam int ROOT_CODES = 2 ** CFG_W;

    // Config and allocator (control state)
    logic [PW-1:0]          r_root_page;
    logic                   r_nx;
    logic [NW-1:0]          r_nfp;
    logic [ENTRY_IDX_W-1:0] r_clr_idx;
    logic                   r_out_valid;

    // Item and walk payload
    logic [TOP_IDX_W-1:0]   r_top_idx;
    logic [ENTRY_IDX_W-1:0] r_dir_idx;
    logic [ENTRY_IDX_W-1:0] r_leaf_idx;
    logic [PPN_W-1:0]       r_phys;
    logic                   r_wr;
    logic                   r_user;
    logic                   r_shared;
    logic                   r_nx_req;
    logic [PW-1:0]          r_dir_page;
    logic [PW-1:0]          r_leaf_page;
    logic [ADDED_W-1:0]     r_added;
    t_status                r_pend_status;
    logic [ENTRY_W-1:0]     r_pend_entry;
    t_status                r_out_status;
    logic [ADDED_W-1:0]     r_out_added;
    logic [ENTRY_W-1:0]     r_out_entry;

    logic [PW-1:0]          w_root_lut [ROOT_CODES];
    logic [ENTRY_W-1:0]     w_rd_data;
    logic [PW-1:0]          w_rd_page;
    logic [PW-1:0]          w_clr_page;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    logic [ENTRY_W-1:0]     w_wr_data;
    logic [ENTRY_W-1:0]     w_leaf_new;
    logic                   w_clr_step;

    // Root register reduced modulo the page count, one entry per register code
    for (genvar g = 0; g < ROOT_CODES; g++) begin : g_root_lut
        assign w_root_lut[g] = PW'(g % TABLE_PAGES);
    end

    assign w_rd_page  = w_rd_data[PFN_LSB +: PW];
    assign w_clr_step = i_cmd.wr_en && (i_cmd.wr_sel == WR_CLEAR);

    assign w_leaf_new = {r_nx_req & r_nx, 9'd0, r_shared, 13'd0, r_phys,
                         9'd0, r_user, r_wr, 1'b1};

    always_comb begin
        case (i_cmd.clr_sel)
            CLR_PAGE_ZERO: w_clr_page = '0;
            CLR_DIR_PAGE:  w_clr_page = r_dir_page;
            CLR_LEAF_PAGE: w_clr_page = r_leaf_page;
            default:       w_clr_page = '0;
        endcase
    end

    // Read address: next level page comes straight off the read port
    always_comb begin
        case (i_cmd.rd_sel)
            RD_TOP:  w_rd_addr = {r_root_page, ENTRY_IDX_W'(r_top_idx)};
            RD_DIR:  w_rd_addr = {w_rd_page, r_dir_idx};
            RD_LEAF: w_rd_addr = {w_rd_page, r_leaf_idx};
            default: w_rd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WR_CLEAR: begin
                w_wr_addr = {w_clr_page, r_clr_idx};
                w_wr_data = '0;
            end
            WR_TOP_LINK: begin
                w_wr_addr = {r_root_page, ENTRY_IDX_W'(r_top_idx)};
                w_wr_data = (ENTRY_W'(r_dir_page) << PFN_LSB) | LINK_TOP_FLAGS;
            end
            WR_DIR_LINK: begin
                w_wr_addr = {r_dir_page, r_dir_idx};
                w_wr_data = (ENTRY_W'(r_leaf_page) << PFN_LSB) | LINK_DIR_FLAGS;
            end
            WR_LEAF: begin
                w_wr_addr = {r_leaf_page, r_leaf_idx};
                w_wr_data = w_leaf_new;
            end
            default: begin
                w_wr_addr = '0;
                w_wr_data = '0;
            end
        endcase
    end

    ptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_page <= w_root_lut[ROOT_RST];
            r_nx        <= 1'b0;
            r_nfp       <= NW'(FREE_BASE_RST);
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROOT:      r_root_page <= w_root_lut[i_cfg_data];
                    CFG_FREE_BASE: r_nfp       <= NW'(i_cfg_data);
                    CFG_NX:        r_nx        <= i_cfg_data[0];
                    default:       ;
                endcase
            end else if (i_cmd.take_dir || i_cmd.take_leaf) begin
                r_nfp <= r_nfp + NW'(1);
            end
            if (w_clr_step) begin
                r_clr_idx <= r_clr_idx + ENTRY_IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_top_idx  <= i_virt_page[2*ENTRY_IDX_W +: TOP_IDX_W];
            r_dir_idx  <= i_virt_page[ENTRY_IDX_W +: ENTRY_IDX_W];
            r_leaf_idx <= i_virt_page[ENTRY_IDX_W-1:0];
            r_phys     <= i_phys_page;
            r_wr       <= i_allow_write;
            r_user     <= i_allow_user;
            r_shared   <= i_mark_shared;
            r_nx_req   <= i_want_no_exec;
            r_added    <= '0;
        end else if (i_cmd.take_dir || i_cmd.take_leaf) begin
            r_added <= r_added + ADDED_W'(1);
        end
        if (i_cmd.cap_dir) begin
            r_dir_page <= w_rd_page;
        end else if (i_cmd.take_dir) begin
            r_dir_page <= r_nfp[PW-1:0];
        end
        if (i_cmd.cap_leaf) begin
            r_leaf_page <= w_rd_page;
        end else if (i_cmd.take_leaf) begin
            r_leaf_page <= r_nfp[PW-1:0];
        end
        if (i_cmd.pend_en) begin
            r_pend_status <= i_cmd.pend_kind;
            case (i_cmd.pend_kind)
                ST_MAPPED:  r_pend_entry <= w_leaf_new;
                ST_PRESENT: r_pend_entry <= w_rd_data;
                ST_NO_ROOM: r_pend_entry <= '0;
                default:    r_pend_entry <= '0;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_pend_status;
            r_out_added  <= (r_pend_status == ST_MAPPED) ? r_added : '0;
            r_out_entry  <= r_pend_entry;
        end
    end

    assign o_sts.present  = w_rd_data[0];
    assign o_sts.clr_last = (r_clr_idx == '1);
    assign o_sts.room_one = (r_nfp < NW'(TABLE_PAGES));
    assign o_sts.room_two = ((NW+1)'(r_nfp) + (NW+1)'(2)) <= (NW+1)'(TABLE_PAGES);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_tables_added = r_out_added;
    assign o_leaf_entry   = r_out_entry;

endmodule

@@ hw/rtl/ptm_checker.sv @@
// Port-level checks on the mapper's result channel, bound to the top level.
module ptm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [ptm_pkg::STATUS_W-1:0]  o_status,
    input logic [ptm_pkg::ADDED_W-1:0]   o_tables_added,
    input logic [ptm_pkg::ENTRY_W-1:0]   o_leaf_entry
);
    import ptm_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_tables_added) && $stable(o_leaf_entry))
        else $error("result changed while stalled");

    // Only mapped results allocate tables, and never more than two
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_MAPPED && o_tables_added != 2'd3)
            || o_tables_added == 2'd0)
        else $error("tables_added inconsistent with status");

    // Out of pages reports an empty entry
    a_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_NO_ROOM |-> o_leaf_entry == '0)
        else $error("no-room result with nonzero entry");

    // Mapped or already present leaf always carries the present bit
    a_leaf_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_MAPPED || o_status == ST_PRESENT)
            |-> o_leaf_entry[0])
        else $error("leaf entry without present bit");

    // Status code is one of the three defined
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_MAPPED || o_status == ST_PRESENT
            || o_status == ST_NO_ROOM)
        else $error("undefined status code");

endmodule

bind pae_page_table_mapper ptm_checker u_ptm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_tables_added (o_tables_added),
    .o_leaf_entry   (o_leaf_entry)
);

@@ tb/tb_pae_page_table_mapper.sv @@
// Self-checking testbench for the PAE page table mapper: table walk, allocation and leaf writes.
module tb_pae_page_table_mapper;
    import ptm_pkg::*;

    localparam int PG_W        = $clog2(PTM_TABLE_PAGES);
    localparam int SLOT_W      = PG_W + ENTRY_IDX_W;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS  = 120;          // per random phase, four phases

    // Leaf entry flag positions
    localparam int LEAF_WR_BIT  = 1;
    localparam int LEAF_USR_BIT = 2;
    localparam int LEAF_SHR_BIT = 53;
    localparam int LEAF_NX_BIT  = 63;

    // Request item as the driver presents it
    typedef struct {
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        logic             wr;
        logic             usr;
        logic             shr;
        logic             nx;
    } t_map_req;

    // Predicted result item; vpn kept only for error reports
    typedef struct {
        logic [VPN_W-1:0]   vpn;
        t_status            status;
        logic [ADDED_W-1:0] added;
        logic [ENTRY_W-1:0] leaf;
    } t_map_res;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [VPN_W-1:0]     i_virt_page    = '0;
    logic [PPN_W-1:0]     i_phys_page    = '0;
    logic                 i_allow_write  = 1'b0;
    logic                 i_allow_user   = 1'b0;
    logic                 i_mark_shared  = 1'b0;
    logic                 i_want_no_exec = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDED_W-1:0]   o_tables_added;
    logic [ENTRY_W-1:0]   o_leaf_entry;

    pae_page_table_mapper uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_virt_page    (i_virt_page),
        .i_phys_page    (i_phys_page),
        .i_allow_write  (i_allow_write),
        .i_allow_user   (i_allow_user),
        .i_mark_shared  (i_mark_shared),
        .i_want_no_exec (i_want_no_exec),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_tables_added (o_tables_added),
        .o_leaf_entry   (o_leaf_entry)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow of the mapper: table memory, allocator and registers.
    // page_clean marks pages whose entries are all defined (page 0 from
    // reset, any page once the allocator has cleared it). The walk
    // refuses requests that would read a page outside that set.
    // ---------------------------------------------------------------
    logic [ENTRY_W-1:0]         tbl_mem [0:PTM_TABLE_PAGES*512-1];
    logic [PTM_TABLE_PAGES-1:0] page_clean;
    logic [PG_W:0]              alloc_next;
    logic [PG_W-1:0]            cfg_root;
    logic                       cfg_nx;

    t_map_req         req_pending  [$];   // items not yet presented
    t_map_res         want_results [$];   // predicted results, oldest first
    logic [VPN_W-1:0] vpn_seen     [$];   // recent pages, reused for table hits

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   bad_count = 0;
    int   cycle_count = 0;
    logic in_taken = 1'b0;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PG_W-1:0] pg,
                                                   input logic [ENTRY_IDX_W-1:0] idx);
        return {pg, idx};
    endfunction

    // Bump allocator: hand out next page (mod page count) and clear it
    function automatic void grab_page(output logic [PG_W-1:0] pg);
        pg = alloc_next[PG_W-1:0];
        alloc_next++;
        for (int e = 0; e < 512; e++)
            tbl_mem[slot_of(pg, e[ENTRY_IDX_W-1:0])] = '0;
        page_clean[pg] = 1'b1;
    endfunction

    // Walk, allocate and write the leaf. ok = 0 means the walk would touch
    // a never-written page; state is left untouched in that case.
    function automatic void map_page(input t_map_req rq, output bit ok,
                                     output t_map_res rs);
        logic [TOP_IDX_W-1:0]   ti;
        logic [ENTRY_IDX_W-1:0] di;
        logic [ENTRY_IDX_W-1:0] li;
        logic [PG_W-1:0]        dpage;
        logic [PG_W-1:0]        lpage;
        logic [ENTRY_W-1:0]     ent;
        int                     need;
        int                     avail;
        ti    = rq.vpn[19:18];
        di    = rq.vpn[17:9];
        li    = rq.vpn[8:0];
        dpage = '0;
        lpage = '0;
        need  = 0;
        ok    = 0;
        rs    = '{vpn: rq.vpn, status: ST_MAPPED, added: '0, leaf: '0};
        if (!page_clean[cfg_root]) return;
        ent = tbl_mem[slot_of(cfg_root, {7'd0, ti})];
        if (!ent[0]) begin
            need = 2;
        end else begin
            // page field taken modulo the page count: low bits only
            dpage = ent[PFN_LSB +: PG_W];
            if (!page_clean[dpage]) return;
            ent = tbl_mem[slot_of(dpage, di)];
            if (!ent[0]) begin
                need = 1;
            end else begin
                lpage = ent[PFN_LSB +: PG_W];
                if (!page_clean[lpage]) return;
                ent = tbl_mem[slot_of(lpage, li)];
                if (ent[0]) begin
                    // leaf already present: no change, report existing entry
                    ok = 1;
                    rs.status = ST_PRESENT;
                    rs.leaf   = ent;
                    return;
                end
            end
        end
        ok = 1;
        avail = (alloc_next < PTM_TABLE_PAGES) ? PTM_TABLE_PAGES - alloc_next : 0;
        if (need > avail) begin
            rs.status = ST_NO_ROOM;
            return;
        end
        if (need == 2) begin
            grab_page(dpage);
            rs.added++;
            tbl_mem[slot_of(cfg_root, {7'd0, ti})] =
                LINK_TOP_FLAGS | (ENTRY_W'(dpage) << PFN_LSB);
        end
        if (need >= 1) begin
            grab_page(lpage);
            rs.added++;
            tbl_mem[slot_of(dpage, di)] = LINK_DIR_FLAGS | (ENTRY_W'(lpage) << PFN_LSB);
        end
        ent = 64'h1 | (ENTRY_W'(rq.ppn) << PFN_LSB);
        ent[LEAF_WR_BIT]  = rq.wr;
        ent[LEAF_USR_BIT] = rq.usr;
        ent[LEAF_SHR_BIT] = rq.shr;
        ent[LEAF_NX_BIT]  = rq.nx & cfg_nx;
        tbl_mem[slot_of(lpage, li)] = ent;
        rs.status = ST_MAPPED;
        rs.leaf   = ent;
    endfunction

    // Predict an item and queue it; unsafe walks are dropped (returns 0)
    function automatic bit queue_item(input t_map_req rq);
        bit       ok;
        t_map_res rs;
        map_page(rq, ok, rs);
        if (ok) begin
            req_pending.push_back(rq);
            want_results.push_back(rs);
            vpn_seen.push_back(rq.vpn);
            if (vpn_seen.size() > 64) void'(vpn_seen.pop_front());
        end
        return ok;
    endfunction

    // flags = {no_exec, shared, user, write}
    task automatic push_directed(input logic [VPN_W-1:0] vpn, input logic [PPN_W-1:0] ppn,
                                 input logic [3:0] flags);
        t_map_req rq;
        rq = '{vpn: vpn, ppn: ppn, wr: flags[0], usr: flags[1], shr: flags[2], nx: flags[3]};
        void'(queue_item(rq));
    endtask

    // Mostly requests that land in existing tables, some new directories,
    // some fully random pages that usually need fresh tables.
    task automatic push_random(input int count);
        t_map_req         rq;
        logic [VPN_W-1:0] anchor;
        logic [31:0]      rnd;
        int               pick;
        int               tries;
        for (int k = 0; k < count; k++) begin
            tries = 0;
            do begin
                pick = $urandom_range(0, 99);
                rnd  = $urandom();
                if (vpn_seen.size() == 0 || pick >= 85) begin
                    rq.vpn = rnd[VPN_W-1:0];
                end else begin
                    anchor = vpn_seen[$urandom_range(0, vpn_seen.size() - 1)];
                    if (pick < 25)      rq.vpn = anchor;
                    else if (pick < 60) rq.vpn = {anchor[19:9], rnd[8:0]};
                    else                rq.vpn = {anchor[19:18], rnd[17:0]};
                end
                rnd = $urandom();
                case ($urandom_range(0, 9))
                    0:       rq.ppn = '0;
                    1:       rq.ppn = '1;
                    default: rq.ppn = rnd[PPN_W-1:0];
                endcase
                rnd    = $urandom();
                rq.wr  = rnd[0];
                rq.usr = rnd[1];
                rq.shr = rnd[2];
                rq.nx  = rnd[3];
                tries++;
            end while (!queue_item(rq) && tries < 32);
        end
    endtask

    // Sender holds off until every predicted result has come back
    task automatic drain();
        while (req_pending.size() != 0 || want_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write all three registers while idle, then mirror them in the shadow
    task automatic set_config(input logic [PG_W-1:0] root, input logic [PG_W-1:0] base,
                              input logic nx);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROOT;
        i_cfg_data <= root;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_FREE_BASE;
        i_cfg_data <= base;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_NX;
        i_cfg_data <= {{(CFG_W-1){1'b0}}, nx};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_root      = root;
        alloc_next    = {1'b0, base};   // base write reloads the allocator
        cfg_nx        = nx;
    endtask

    // Root only ever points at a page whose entries are defined
    function automatic logic [PG_W-1:0] clean_root();
        logic [PG_W-1:0] pg;
        do pg = PG_W'($urandom_range(0, PTM_TABLE_PAGES - 1)); while (!page_clean[pg]);
        return pg;
    endfunction

    // ---------------------------------------------------------------
    // Driver: payload and valid change on the falling edge only.
    // A held item stays put until in_taken shows it was accepted.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_map_req rq;
        logic     hold;
        hold = i_in_valid && !in_taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!hold) begin
            if (req_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rq = req_pending.pop_front();
                i_virt_page    <= rq.vpn;
                i_phys_page    <= rq.ppn;
                i_allow_write  <= rq.wr;
                i_allow_user   <= rq.usr;
                i_mark_shared  <= rq.shr;
                i_want_no_exec <= rq.nx;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: sample handshakes at the rising edge, check each result
    // against the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_map_res w;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (want_results.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("ERROR: unexpected result status=%0d added=%0d leaf=%h",
                             o_status, o_tables_added, o_leaf_entry);
            end else begin
                w = want_results.pop_front();
                if (o_status !== w.status || o_tables_added !== w.added ||
                    o_leaf_entry !== w.leaf) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $write("ERROR: vpn %h exp status=%0d added=%0d leaf=%h",
                               w.vpn, w.status, w.added, w.leaf);
                        $display(" got status=%0d added=%0d leaf=%h",
                                 o_status, o_tables_added, o_leaf_entry);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        // Shadow reset: only the root page is defined, allocator at base
        for (int e = 0; e < 512; e++) tbl_mem[e] = '0;
        page_clean    = '0;
        page_clean[0] = 1'b1;
        cfg_root      = ROOT_RST;
        alloc_next    = {1'b0, FREE_BASE_RST};
        cfg_nx        = 1'b0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values, no idling.
        // Fresh directory + table, hit, field extremes, new table only.
        push_directed(20'h00000, 28'h0000000, 4'h0);
        push_directed(20'h00000, 28'h1234567, 4'hF);
        push_directed(20'h00001, 28'hFFFFFFF, 4'hF);   // no-exec asked, NX off
        push_directed(20'h001FF, 28'h5555555, 4'h5);
        push_directed(20'h00200, 28'hAAAAAAA, 4'hA);
        push_directed(20'hFFFFF, 28'hFFFFFFF, 4'hF);
        push_directed(20'hFFFFF, 28'h0000000, 4'h0);
        push_directed(20'h7FE00, 28'h0000001, 4'h3);
        push_directed(20'h80000, 28'h0000002, 4'hC);
        drain();

        // Two pages left: NX honored, then the allocator runs dry
        set_config(6'd0, 6'd62, 1'b1);
        push_directed(20'h3FFFF, 28'h0ABCDEF, 4'hF);
        push_directed(20'h3FE00, 28'h0000003, 4'h7);
        push_directed(20'h3FC00, 28'h0000041, 4'h8);   // leaf lands in page 63
        push_directed(20'h3FA00, 28'h0000004, 4'h1);
        push_directed(20'h40000, 28'h0000005, 4'h2);
        drain();

        // Root at the top page, whose entry 0 is a leaf with an oversized page
        // number; one page left, handed out over the live root itself.
        set_config(6'd63, 6'd63, 1'b1);
        push_directed(20'h00000, 28'h0000006, 4'h0);
        push_directed(20'h40000, 28'h0000007, 4'h0);
        push_directed(20'h00A00, 28'h0000002, 4'hE);
        push_directed(20'h00000, 28'h0000008, 4'h0);
        push_directed(20'hC0000, 28'h0000009, 4'h9);
        drain();

        // Random phases, each a different idling pattern and setting
        set_config(6'd0, 6'd1, 1'b1);
        push_random(RAND_ITEMS);
        drain();

        send_idle_pct  = 83;
        recv_stall_pct = 0;
        set_config(clean_root(), PG_W'($urandom_range(1, 40)), 1'b0);
        push_random(RAND_ITEMS);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        set_config(clean_root(), PG_W'($urandom_range(1, 63)), 1'b1);
        push_random(RAND_ITEMS);
        drain();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        set_config(clean_root(), 6'd1, 1'($urandom_range(0, 1)));
        push_random(RAND_ITEMS);
        drain();

        repeat (20) @(negedge i_clk);
        if (bad_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_ram.sv
hw/rtl/ptm_ctrl.sv
hw/rtl/ptm_datapath.sv
hw/rtl/pae_page_table_mapper.sv
hw/rtl/ptm_checker.sv
tb/tb_pae_page_table_mapper.sv
